### src/stochastic_oscillator_defines.svh
// assertion helpers for the stochastic oscillator checker
`ifndef STOCHASTIC_OSCILLATOR_DEFINES_SVH
`define STOCHASTIC_OSCILLATOR_DEFINES_SVH

// condition holds at every clock edge out of reset
`define STO_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define STO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### src/sto_pkg.sv
package sto_pkg;

  localparam int PRICE_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int PCT_W         = 7 + FRACTION_BITS;
  // diff * 100 fits in price bits plus seven
  localparam int RATIO_W       = PRICE_BITS + 7;
  localparam int DVD_W         = RATIO_W + FRACTION_BITS;
  localparam int STEP_W        = $clog2(DVD_W + 1);

  localparam logic [PCT_W-1:0]   PCT_FULL = PCT_W'(100 << FRACTION_BITS);
  localparam logic [PCT_W-1:0]   PCT_HALF = PCT_W'(50 << FRACTION_BITS);
  localparam logic [RATIO_W-1:0] HUNDRED  = RATIO_W'(100);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOKBACK = 2'd0,
    CFG_K_SMOOTH = 2'd1,
    CFG_D_SMOOTH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PRICE_BITS-1:0] high_price;
    logic [PRICE_BITS-1:0] low_price;
    logic [PRICE_BITS-1:0] close_tick;
  } in_t;

  typedef struct packed {
    logic [PCT_W-1:0] k_percent;
    logic             k_valid;
    logic [PCT_W-1:0] d_percent;
    logic             d_valid;
  } out_t;

  // running extremes handed from cell to cell
  typedef struct packed {
    logic                  vld;
    logic [PRICE_BITS-1:0] hmax;
    logic [PRICE_BITS-1:0] lmin;
  } scan_t;

  typedef struct packed {
    logic                  start;
    logic [DVD_W-1:0]      dividend;
    logic [PRICE_BITS-1:0] divisor;
    logic [STEP_W-1:0]     steps;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RGO,
    ST_RDIV,
    ST_KSUM,
    ST_KGO,
    ST_KDIV,
    ST_DSUM,
    ST_DGO,
    ST_DDIV,
    ST_OUT
  } state_e;

endpackage

### src/sto_ram.sv
module sto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/sto_cell.sv
module sto_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            shift_i,
  input  logic                            active_i,
  input  logic [sto_pkg::PRICE_BITS-1:0]  high_i,
  input  logic [sto_pkg::PRICE_BITS-1:0]  low_i,
  output logic [sto_pkg::PRICE_BITS-1:0]  high_o,
  output logic [sto_pkg::PRICE_BITS-1:0]  low_o,
  input  sto_pkg::scan_t                  scan_i,
  output sto_pkg::scan_t                  scan_o
);

  logic [sto_pkg::PRICE_BITS-1:0] high_q;
  logic [sto_pkg::PRICE_BITS-1:0] low_q;
  logic [sto_pkg::PRICE_BITS-1:0] hmax_d, hmax_q;
  logic [sto_pkg::PRICE_BITS-1:0] lmin_d, lmin_q;
  logic                           vld_q;

  // cells beyond the lookback pass the extremes through untouched
  always_comb begin
    hmax_d = (active_i && (high_q > scan_i.hmax)) ? high_q : scan_i.hmax;
    lmin_d = (active_i && (low_q < scan_i.lmin)) ? low_q : scan_i.lmin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= scan_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      high_q <= high_i;
      low_q  <= low_i;
    end
    hmax_q <= hmax_d;
    lmin_q <= lmin_d;
  end

  assign high_o      = high_q;
  assign low_o       = low_q;
  assign scan_o.vld  = vld_q;
  assign scan_o.hmax = hmax_q;
  assign scan_o.lmin = lmin_q;

endmodule

### src/sto_div.sv
module sto_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sto_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [sto_pkg::PCT_W-1:0]   quotient_o
);

  logic [sto_pkg::DVD_W-1:0]      dvd_q;
  logic [sto_pkg::PRICE_BITS-1:0] dvs_q;
  logic [sto_pkg::PRICE_BITS-1:0] rem_q;
  logic [sto_pkg::PCT_W-1:0]      quo_q;
  logic [sto_pkg::STEP_W-1:0]     cnt_q;
  logic                           busy_q;
  logic                           done_q;

  logic [sto_pkg::PRICE_BITS:0]   rem_sh;
  logic [sto_pkg::PRICE_BITS:0]   rem_sub;
  logic                           fits;

  // one restoring step per cycle, dividend bits taken from the top
  always_comb begin
    rem_sh  = {rem_q, dvd_q[sto_pkg::DVD_W-1]};
    fits    = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != sto_pkg::STEP_W'(1));
      done_q <= (cnt_q == sto_pkg::STEP_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[sto_pkg::DVD_W-2:0], 1'b0};
      rem_q <= fits ? rem_sub[sto_pkg::PRICE_BITS-1:0] : rem_sh[sto_pkg::PRICE_BITS-1:0];
      quo_q <= {quo_q[sto_pkg::PCT_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### src/stochastic_oscillator.sv
// channel   direction  handshake                 item
// cfg       in         cfg_we_i                  cfg_addr_i, cfg_wdata_i
// in        in         in_valid_i / in_stall_o   high, low, close price
// out       out        out_valid_o / out_stall_i %K, %K valid, %D, %D valid
//
// one bar at a time: a scan along the cell row, a ratio divide (skipped on flat or
// clipped bars), then the %K and %D sum divides and an output step; in warm-up the
// divides not yet due are skipped.
// in_stall_o is high from acceptance until the result is loaded into the output register.
// reset and writes to used config indices clear bar count, ring positions, running sums.
// a stalled result sits in the output register while the next bar is already taken.
module stochastic_oscillator #(
  parameter int MAX_LOOKBACK = 64,
  parameter int MAX_K_SMOOTH = 16,
  parameter int MAX_D_SMOOTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sto_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [sto_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  sto_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sto_pkg::out_t                     out_data_o
);

  localparam int BARS_CAP = MAX_LOOKBACK + MAX_K_SMOOTH + MAX_D_SMOOTH;
  localparam int CNT_W    = $clog2(BARS_CAP + 1);
  localparam int TH_W     = CNT_W + 2;
  localparam int LEN_W    = $clog2(MAX_LOOKBACK + 1);
  localparam int KS_W     = $clog2(MAX_K_SMOOTH + 1);
  localparam int DS_W     = $clog2(MAX_D_SMOOTH + 1);
  localparam int KAW      = (MAX_K_SMOOTH > 1) ? $clog2(MAX_K_SMOOTH) : 1;
  localparam int DAW      = (MAX_D_SMOOTH > 1) ? $clog2(MAX_D_SMOOTH) : 1;
  localparam int KSUM_W   = sto_pkg::PCT_W + $clog2(MAX_K_SMOOTH + 1);
  localparam int DSUM_W   = sto_pkg::PCT_W + $clog2(MAX_D_SMOOTH + 1);
  localparam int LEN_RST  = (14 > MAX_LOOKBACK) ? MAX_LOOKBACK : 14;
  localparam int KS_RST   = (3 > MAX_K_SMOOTH) ? MAX_K_SMOOTH : 3;
  localparam int DS_RST   = (3 > MAX_D_SMOOTH) ? MAX_D_SMOOTH : 3;
  localparam int PB       = sto_pkg::PRICE_BITS;
  localparam int PW       = sto_pkg::PCT_W;

  sto_pkg::state_e state_d, state_q;

  logic [LEN_W-1:0]  len_q;
  logic [KS_W-1:0]   ks_q;
  logic [DS_W-1:0]   ds_q;
  logic [CNT_W-1:0]  n_q;
  logic              start_q;
  logic [PB-1:0]     close_q;
  logic [PB-1:0]     diff_q;
  logic [PB-1:0]     range_q;
  logic [PW-1:0]     raw_q;
  logic [PW-1:0]     kval_q;
  logic              kv_q;
  logic [PW-1:0]     dval_q;
  logic              dv_q;
  logic [KSUM_W-1:0] raw_sum_q;
  logic [DSUM_W-1:0] sm_sum_q;
  logic [KAW-1:0]    raw_pos_q;
  logic [DAW-1:0]    sm_pos_q;
  sto_pkg::out_t     out_q;
  logic              out_valid_q;

  logic              accept;
  logic              out_free;
  logic              flat, below, above;
  logic [TH_W-1:0]   len_ks, len_ks_ds;
  logic              n_lt_len, sub_k, k_ok, sub_d, d_ok;
  logic [KAW:0]      raw_rd_tmp;
  logic [KAW-1:0]    raw_raddr;
  logic [DAW:0]      sm_rd_tmp;
  logic [DAW-1:0]    sm_raddr;
  logic [PW-1:0]     raw_rdata, sm_rdata;
  logic [LEN_W-1:0]  len_wr;
  logic [KS_W-1:0]   ks_wr;
  logic [DS_W-1:0]   ds_wr;

  sto_pkg::div_req_t div_req;
  logic              div_done;
  logic [PW-1:0]     div_quo;

  // cell row: price shift line plus the extremes scan
  logic [PB-1:0]  hi_chain [MAX_LOOKBACK+1];
  logic [PB-1:0]  lo_chain [MAX_LOOKBACK+1];
  sto_pkg::scan_t scan_chain [MAX_LOOKBACK+1];

  assign hi_chain[0]        = in_data_i.high_price;
  assign lo_chain[0]        = in_data_i.low_price;
  assign scan_chain[0].vld  = start_q;
  assign scan_chain[0].hmax = '0;
  assign scan_chain[0].lmin = '1;

  for (genvar i = 0; i < MAX_LOOKBACK; i++) begin : g_cell
    sto_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept),
      .active_i (32'(len_q) > 32'(i)),
      .high_i   (hi_chain[i]),
      .low_i    (lo_chain[i]),
      .high_o   (hi_chain[i+1]),
      .low_o    (lo_chain[i+1]),
      .scan_i   (scan_chain[i]),
      .scan_o   (scan_chain[i+1])
    );
  end

  sto_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // oldest ring entry still in the average sits ks places back
  always_comb begin
    raw_rd_tmp = (KAW+1)'(raw_pos_q) + (KAW+1)'(MAX_K_SMOOTH) - (KAW+1)'(ks_q);
    if (raw_rd_tmp >= (KAW+1)'(MAX_K_SMOOTH)) begin
      raw_rd_tmp = raw_rd_tmp - (KAW+1)'(MAX_K_SMOOTH);
    end
    raw_raddr = raw_rd_tmp[KAW-1:0];
    sm_rd_tmp = (DAW+1)'(sm_pos_q) + (DAW+1)'(MAX_D_SMOOTH) - (DAW+1)'(ds_q);
    if (sm_rd_tmp >= (DAW+1)'(MAX_D_SMOOTH)) begin
      sm_rd_tmp = sm_rd_tmp - (DAW+1)'(MAX_D_SMOOTH);
    end
    sm_raddr = sm_rd_tmp[DAW-1:0];
  end

  sto_ram #(.WIDTH(PW), .DEPTH(MAX_K_SMOOTH)) u_raw_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == sto_pkg::ST_KSUM),
    .waddr_i (raw_pos_q),
    .wdata_i (raw_q),
    .raddr_i (raw_raddr),
    .rdata_o (raw_rdata)
  );

  sto_ram #(.WIDTH(PW), .DEPTH(MAX_D_SMOOTH)) u_sm_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == sto_pkg::ST_DSUM),
    .waddr_i (sm_pos_q),
    .wdata_i (kval_q),
    .raddr_i (sm_raddr),
    .rdata_o (sm_rdata)
  );

  // register writes, lengths clamped to 1..max, smoothing lengths from the low five bits
  always_comb begin
    if (cfg_wdata_i == '0) begin
      len_wr = LEN_W'(1);
    end else if (32'(cfg_wdata_i) > 32'(MAX_LOOKBACK)) begin
      len_wr = LEN_W'(MAX_LOOKBACK);
    end else begin
      len_wr = LEN_W'(cfg_wdata_i);
    end
    if (cfg_wdata_i[4:0] == '0) begin
      ks_wr = KS_W'(1);
    end else if (32'(cfg_wdata_i[4:0]) > 32'(MAX_K_SMOOTH)) begin
      ks_wr = KS_W'(MAX_K_SMOOTH);
    end else begin
      ks_wr = KS_W'(cfg_wdata_i[4:0]);
    end
    if (cfg_wdata_i[4:0] == '0) begin
      ds_wr = DS_W'(1);
    end else if (32'(cfg_wdata_i[4:0]) > 32'(MAX_D_SMOOTH)) begin
      ds_wr = DS_W'(MAX_D_SMOOTH);
    end else begin
      ds_wr = DS_W'(cfg_wdata_i[4:0]);
    end
  end

  always_comb begin
    accept    = in_valid_i && (state_q == sto_pkg::ST_IDLE);
    out_free  = !out_valid_q || !out_stall_i;
    flat      = scan_chain[MAX_LOOKBACK].hmax <= scan_chain[MAX_LOOKBACK].lmin;
    below     = close_q <= scan_chain[MAX_LOOKBACK].lmin;
    above     = close_q >= scan_chain[MAX_LOOKBACK].hmax;
    len_ks    = TH_W'(len_q) + TH_W'(ks_q);
    len_ks_ds = len_ks + TH_W'(ds_q);
    n_lt_len  = TH_W'(n_q) < TH_W'(len_q);
    sub_k     = TH_W'(n_q) >= len_ks;
    k_ok      = (TH_W'(n_q) + TH_W'(1)) >= len_ks;
    sub_d     = (TH_W'(n_q) + TH_W'(1)) >= len_ks_ds;
    d_ok      = (TH_W'(n_q) + TH_W'(2)) >= len_ks_ds;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sto_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = sto_pkg::ST_SCAN;
        end
      end
      sto_pkg::ST_SCAN: begin
        if (scan_chain[MAX_LOOKBACK].vld) begin
          if (n_lt_len) begin
            state_d = sto_pkg::ST_OUT;
          end else if (flat || below || above) begin
            state_d = sto_pkg::ST_KSUM;
          end else begin
            state_d = sto_pkg::ST_RGO;
          end
        end
      end
      sto_pkg::ST_RGO:  state_d = sto_pkg::ST_RDIV;
      sto_pkg::ST_RDIV: begin
        if (div_done) begin
          state_d = sto_pkg::ST_KSUM;
        end
      end
      sto_pkg::ST_KSUM: state_d = k_ok ? sto_pkg::ST_KGO : sto_pkg::ST_OUT;
      sto_pkg::ST_KGO:  state_d = sto_pkg::ST_KDIV;
      sto_pkg::ST_KDIV: begin
        if (div_done) begin
          state_d = sto_pkg::ST_DSUM;
        end
      end
      sto_pkg::ST_DSUM: state_d = d_ok ? sto_pkg::ST_DGO : sto_pkg::ST_OUT;
      sto_pkg::ST_DGO:  state_d = sto_pkg::ST_DDIV;
      sto_pkg::ST_DDIV: begin
        if (div_done) begin
          state_d = sto_pkg::ST_OUT;
        end
      end
      sto_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = sto_pkg::ST_IDLE;
        end
      end
      default: state_d = sto_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    div_req          = '0;
    div_req.start    = 1'b0;
    unique case (state_q)
      sto_pkg::ST_RGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {sto_pkg::RATIO_W'(diff_q) * sto_pkg::HUNDRED,
                            sto_pkg::FRACTION_BITS'(0)};
        div_req.divisor  = range_q;
        div_req.steps    = sto_pkg::STEP_W'(sto_pkg::DVD_W);
      end
      sto_pkg::ST_KGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {raw_sum_q, (sto_pkg::DVD_W-KSUM_W)'(0)};
        div_req.divisor  = PB'(ks_q);
        div_req.steps    = sto_pkg::STEP_W'(KSUM_W);
      end
      sto_pkg::ST_DGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {sm_sum_q, (sto_pkg::DVD_W-DSUM_W)'(0)};
        div_req.divisor  = PB'(ds_q);
        div_req.steps    = sto_pkg::STEP_W'(DSUM_W);
      end
      default: div_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sto_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LEN_W'(LEN_RST);
      ks_q      <= KS_W'(KS_RST);
      ds_q      <= DS_W'(DS_RST);
      n_q       <= '0;
      start_q   <= 1'b0;
      raw_sum_q <= '0;
      sm_sum_q  <= '0;
      raw_pos_q <= '0;
      sm_pos_q  <= '0;
    end else begin
      start_q <= accept;
      if (cfg_we_i && ((cfg_addr_i == sto_pkg::CFG_LOOKBACK) ||
                       (cfg_addr_i == sto_pkg::CFG_K_SMOOTH) ||
                       (cfg_addr_i == sto_pkg::CFG_D_SMOOTH))) begin
        unique case (cfg_addr_i)
          sto_pkg::CFG_LOOKBACK: len_q <= len_wr;
          sto_pkg::CFG_K_SMOOTH: ks_q  <= ks_wr;
          sto_pkg::CFG_D_SMOOTH: ds_q  <= ds_wr;
          default: len_q <= len_q;
        endcase
        n_q       <= '0;
        raw_sum_q <= '0;
        sm_sum_q  <= '0;
        raw_pos_q <= '0;
        sm_pos_q  <= '0;
      end else begin
        if (accept && (n_q != CNT_W'(BARS_CAP))) begin
          n_q <= n_q + 1'b1;
        end
        if (state_q == sto_pkg::ST_KSUM) begin
          raw_sum_q <= raw_sum_q - (sub_k ? KSUM_W'(raw_rdata) : '0) + KSUM_W'(raw_q);
          raw_pos_q <= (raw_pos_q == KAW'(MAX_K_SMOOTH - 1)) ? '0 : raw_pos_q + 1'b1;
        end
        if (state_q == sto_pkg::ST_DSUM) begin
          sm_sum_q <= sm_sum_q - (sub_d ? DSUM_W'(sm_rdata) : '0) + DSUM_W'(kval_q);
          sm_pos_q <= (sm_pos_q == DAW'(MAX_D_SMOOTH - 1)) ? '0 : sm_pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      close_q <= in_data_i.close_tick;
      kval_q  <= '0;
      kv_q    <= 1'b0;
      dval_q  <= '0;
      dv_q    <= 1'b0;
    end
    if ((state_q == sto_pkg::ST_SCAN) && scan_chain[MAX_LOOKBACK].vld) begin
      diff_q  <= close_q - scan_chain[MAX_LOOKBACK].lmin;
      range_q <= scan_chain[MAX_LOOKBACK].hmax - scan_chain[MAX_LOOKBACK].lmin;
      // flat range reads as midpoint, clipped closes as the ends
      raw_q   <= flat ? sto_pkg::PCT_HALF : (below ? '0 : sto_pkg::PCT_FULL);
    end
    if ((state_q == sto_pkg::ST_RDIV) && div_done) begin
      raw_q <= div_quo;
    end
    if ((state_q == sto_pkg::ST_KDIV) && div_done) begin
      kval_q <= div_quo;
      kv_q   <= 1'b1;
    end
    if ((state_q == sto_pkg::ST_DDIV) && div_done) begin
      dval_q <= div_quo;
      dv_q   <= 1'b1;
    end
    if ((state_q == sto_pkg::ST_OUT) && out_free) begin
      out_q.k_percent <= kval_q;
      out_q.k_valid   <= kv_q;
      out_q.d_percent <= dval_q;
      out_q.d_valid   <= dv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == sto_pkg::ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o  = (state_q != sto_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/sto_checker.sv
`include "stochastic_oscillator_defines.svh"

module sto_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input sto_pkg::out_t out_data_o
);

  `STO_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  `STO_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o), "stalled result changed")

  // %D needs %K history first
  `STO_ASSERT_ALWAYS(a_d_needs_k, !out_valid_o || !out_data_o.d_valid || out_data_o.k_valid, "d valid without k valid")

  `STO_ASSERT_ALWAYS(a_range, !out_valid_o || ((out_data_o.k_percent <= sto_pkg::PCT_FULL) && (out_data_o.d_percent <= sto_pkg::PCT_FULL)), "percent above full scale")

  `STO_ASSERT_ALWAYS(a_warmup_zero, !out_valid_o || ((out_data_o.k_valid || (out_data_o.k_percent == '0)) && (out_data_o.d_valid || (out_data_o.d_percent == '0))), "warm-up value not zero")

endmodule

bind stochastic_oscillator sto_checker u_sto_checker (.*);

### bench/stochastic_oscillator_tb.sv
module stochastic_oscillator_tb;
  import sto_pkg::*;

  localparam int unsigned LOOKBACK_MAX = 64;
  localparam int unsigned KSMOOTH_MAX  = 16;
  localparam int unsigned DSMOOTH_MAX  = 16;
  localparam int unsigned BAR_CAP      = LOOKBACK_MAX + KSMOOTH_MAX + DSMOOTH_MAX;
  localparam int unsigned FRAC_BITS    = 16;
  localparam logic [22:0] PCT_HUNDRED  = 23'(100 << FRAC_BITS);
  localparam logic [22:0] PCT_FIFTY    = 23'(50 << FRAC_BITS);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned HOLD_CYCLES  = 2500;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT  = 1500000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;

  stochastic_oscillator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // oscillator state mirrored by the bench
  logic [6:0]  lookback_reg;
  logic [4:0]  k_smooth_reg;
  logic [4:0]  d_smooth_reg;
  logic [31:0] high_hist [LOOKBACK_MAX];
  logic [31:0] low_hist [LOOKBACK_MAX];
  logic [22:0] raw_hist [KSMOOTH_MAX];
  logic [22:0] k_hist [DSMOOTH_MAX];
  logic [26:0] raw_total;
  logic [26:0] k_total;
  int unsigned bars_in_window;
  int unsigned bar_pos, raw_pos, k_pos;

  out_t        osc_expected_q [$];
  out_t        want;
  int unsigned idle_pct;
  int unsigned stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned bars_sent = 0;
  int unsigned results_checked = 0;
  int unsigned fail_count = 0;
  int unsigned settings_count = 0;
  logic [31:0] trend_price;
  int unsigned price_span_bits;

  function automatic int unsigned clip_length(int unsigned v, int unsigned top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void clear_history();
    for (int i = 0; i < LOOKBACK_MAX; i++) begin
      high_hist[i] = '0;
      low_hist[i] = '0;
    end
    for (int i = 0; i < KSMOOTH_MAX; i++) raw_hist[i] = '0;
    for (int i = 0; i < DSMOOTH_MAX; i++) k_hist[i] = '0;
    raw_total = '0;
    k_total = '0;
    bars_in_window = 0;
    bar_pos = 0;
    raw_pos = 0;
    k_pos = 0;
  endfunction

  function automatic out_t predict_oscillator(in_t bar);
    int unsigned len, ks, ds, n, j, slot;
    logic [31:0] hmax, lmin;
    logic [63:0] diff, span;
    logic [22:0] raw, kval;
    out_t res;
    len = clip_length(lookback_reg, LOOKBACK_MAX);
    ks = clip_length(k_smooth_reg, KSMOOTH_MAX);
    ds = clip_length(d_smooth_reg, DSMOOTH_MAX);
    res = '0;
    n = (bars_in_window < BAR_CAP) ? bars_in_window + 1 : BAR_CAP;
    bars_in_window = n;
    high_hist[bar_pos] = bar.high_price;
    low_hist[bar_pos] = bar.low_price;
    bar_pos = (bar_pos + 1) % LOOKBACK_MAX;
    if (n >= len) begin
      hmax = '0;
      lmin = '1;
      for (j = 1; j <= len; j++) begin
        slot = (bar_pos + LOOKBACK_MAX - j) % LOOKBACK_MAX;
        if (high_hist[slot] > hmax) hmax = high_hist[slot];
        if (low_hist[slot] < lmin) lmin = low_hist[slot];
      end
      if (hmax <= lmin) raw = PCT_FIFTY;
      else if (bar.close_tick <= lmin) raw = '0;
      else if (bar.close_tick >= hmax) raw = PCT_HUNDRED;
      else begin
        diff = 64'(bar.close_tick) - 64'(lmin);
        span = 64'(hmax) - 64'(lmin);
        raw = 23'(((diff * 64'd100) << FRAC_BITS) / span);
      end
      // drop the raw value that falls out of the %K window
      if (n >= len + ks) raw_total = raw_total - raw_hist[(raw_pos + KSMOOTH_MAX - ks) % KSMOOTH_MAX];
      raw_hist[raw_pos] = raw;
      raw_total = raw_total + raw;
      raw_pos = (raw_pos + 1) % KSMOOTH_MAX;
      if (n >= len + ks - 1) begin
        kval = 23'(raw_total / ks);
        res.k_percent = kval;
        res.k_valid = 1'b1;
        if (n >= len + ks + ds - 1) k_total = k_total - k_hist[(k_pos + DSMOOTH_MAX - ds) % DSMOOTH_MAX];
        k_hist[k_pos] = kval;
        k_total = k_total + kval;
        k_pos = (k_pos + 1) % DSMOOTH_MAX;
        if (n >= len + ks + ds - 2) begin
          res.d_percent = 23'(k_total / ds);
          res.d_valid = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic in_t bar_of(logic [31:0] hi, logic [31:0] lo, logic [31:0] cl);
    in_t b;
    b.high_price = hi;
    b.low_price = lo;
    b.close_tick = cl;
    return b;
  endfunction

  // mostly well-formed bars on a random walk, some noise and flat bars
  function automatic in_t random_bar();
    in_t b;
    longint mask, mid, hi, lo, draw;
    int unsigned pick;
    mask = (longint'(1) << price_span_bits) - 1;
    pick = $urandom_range(99);
    if (pick < 12) begin
      b.high_price = $urandom;
      b.low_price = $urandom;
      b.close_tick = $urandom;
    end else begin
      draw = $urandom;
      mid = longint'(trend_price) + (draw & mask) - (mask >>> 1);
      if (mid < 0) mid = 0;
      if (mid > 64'hFFFFFFFF) mid = 64'hFFFFFFFF;
      trend_price = mid[31:0];
      hi = mid;
      lo = mid;
      if (pick >= 18) begin
        draw = $urandom;
        hi = mid + (draw & mask);
        draw = $urandom;
        lo = mid - (draw & mask);
        if (hi > 64'hFFFFFFFF) hi = 64'hFFFFFFFF;
        if (lo < 0) lo = 0;
      end
      draw = $urandom;
      b.high_price = hi[31:0];
      b.low_price = lo[31:0];
      b.close_tick = (pick >= 94) ? $urandom : 32'(lo + draw % (hi - lo + 1));
    end
    return b;
  endfunction

  task automatic send_bar(input in_t bar);
    int unsigned gap;
    in_data_i <= bar;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    osc_expected_q.push_back(predict_oscillator(bar));
    bars_sent++;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (osc_expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_LOOKBACK) lookback_reg = val;
    else if (idx == CFG_K_SMOOTH) k_smooth_reg = val[4:0];
    else if (idx == CFG_D_SMOOTH) d_smooth_reg = val[4:0];
    if (idx == CFG_LOOKBACK || idx == CFG_K_SMOOTH || idx == CFG_D_SMOOTH) clear_history();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] lb, input logic [CFG_DATA_W-1:0] ks,
                               input logic [CFG_DATA_W-1:0] ds);
    wait_idle();
    write_reg(CFG_LOOKBACK, lb);
    write_reg(CFG_K_SMOOTH, ks);
    write_reg(CFG_D_SMOOTH, ds);
    settings_count++;
  endtask

  // extremes, flat and inverted ranges, close outside the window, length clamping
  task automatic test_directed_bars();
    idle_pct = 0;
    load_settings(7'd2, 7'd2, 7'd2);
    send_bar(bar_of(32'd0, 32'd0, 32'd0));
    send_bar(bar_of(32'd0, 32'd0, 32'd0));
    send_bar(bar_of(32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF));
    send_bar(bar_of(32'hFFFFFFFF, 32'd0, 32'd0));
    send_bar(bar_of(32'hFFFFFFFF, 32'd0, 32'h7FFFFFFF));
    send_bar(bar_of(32'hFFFFFFFF, 32'd0, 32'd1));
    send_bar(bar_of(32'd1000, 32'd500, 32'd750));
    send_bar(bar_of(32'd1000, 32'd500, 32'd3));
    send_bar(bar_of(32'd1000, 32'd500, 32'hFFFFFFFF));
    send_bar(bar_of(32'd1000, 32'd500, 32'd1000));
    send_bar(bar_of(32'd200, 32'd900, 32'd500));
    send_bar(bar_of(32'd200, 32'd900, 32'd500));
    send_bar(bar_of(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    send_bar(bar_of(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0));
    // zero lengths act as one
    load_settings(7'd0, 7'd0, 7'd0);
    send_bar(bar_of(32'd20, 32'd10, 32'd15));
    send_bar(bar_of(32'd10, 32'd20, 32'd15));
    send_bar(bar_of(32'd5, 32'd5, 32'd6));
    send_bar(bar_of(32'hAAAAAAAA, 32'h55555555, 32'h80000000));
    // unused index must leave settings and history alone
    wait_idle();
    write_reg(CFG_SPARE, 7'h55);
    send_bar(bar_of(32'd300, 32'd100, 32'd250));
    send_bar(bar_of(32'd300, 32'd100, 32'd100));
    // oversized lengths clamp to the maximum
    load_settings(7'd127, 7'h51, 7'h70);
    send_bar(bar_of(32'd40, 32'd30, 32'd35));
    send_bar(bar_of(32'd50, 32'd20, 32'd45));
    send_bar(bar_of(32'd60, 32'd10, 32'd11));
  endtask

  task automatic test_random_phases();
    int unsigned idle_set [4] = '{0, 70, 0, 9};
    int unsigned stall_set [4] = '{0, 0, 70, 9};
    int unsigned g, count;
    logic [CFG_DATA_W-1:0] lb, ks, ds;
    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 3; s++) begin
        g = p * 3 + s;
        case (g)
          0: load_settings(7'd64, 7'd16, 7'd16);
          1: load_settings(7'd1, 7'd1, 7'd1);
          4: load_settings(7'd127, 7'd31, 7'd31);
          default: begin
            lb = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 64));
            ks = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 16));
            ds = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 16));
            load_settings(lb, ks, ds);
          end
        endcase
        idle_pct = idle_set[p];
        stall_pct <= stall_set[p];
        price_span_bits = $urandom_range(31);
        trend_price = $urandom;
        count = 30 + clip_length(lookback_reg, LOOKBACK_MAX) +
                clip_length(k_smooth_reg, KSMOOTH_MAX) + clip_length(d_smooth_reg, DSMOOTH_MAX);
        repeat (count) send_bar(random_bar());
      end
    end
  endtask

  // receiver holds off long enough for the block to back up its input
  task automatic test_output_hold();
    load_settings(7'd5, 7'd2, 7'd4);
    idle_pct = 0;
    stall_pct <= 0;
    hold_go <= 1'b1;
    price_span_bits = 12;
    trend_price = 32'd100000;
    repeat (30) send_bar(random_bar());
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (osc_expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected: k=%0d/%0b d=%0d/%0b", $time,
                 out_data_o.k_percent, out_data_o.k_valid, out_data_o.d_percent, out_data_o.d_valid);
      end else begin
        want = osc_expected_q.pop_front();
        results_checked++;
        if (out_data_o.k_percent !== want.k_percent || out_data_o.k_valid !== want.k_valid ||
            out_data_o.d_percent !== want.d_percent || out_data_o.d_valid !== want.d_valid) begin
          fail_count++;
          $display("%0t: item %0d expected k=%0d/%0b d=%0d/%0b, actual k=%0d/%0b d=%0d/%0b",
                   $time, results_checked, want.k_percent, want.k_valid, want.d_percent,
                   want.d_valid, out_data_o.k_percent, out_data_o.k_valid,
                   out_data_o.d_percent, out_data_o.d_valid);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               osc_expected_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    lookback_reg = 7'd14;
    k_smooth_reg = 5'd3;
    d_smooth_reg = 5'd3;
    clear_history();
    idle_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_bars();
    test_random_phases();
    test_output_hold();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d bars over %0d register settings, four idle/stall mixes and one long output hold",
             bars_sent, settings_count);
    $display("%0d results compared, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/sto_pkg.sv
src/sto_ram.sv
src/sto_cell.sv
src/sto_div.sv
src/stochastic_oscillator.sv
src/sto_checker.sv
bench/stochastic_oscillator_tb.sv
